>>> src/msp_pkg.sv
// Shared types and constants for the MIDI stream parser.
`timescale 1ns / 1ps
package msp_pkg;

  localparam int SysexBufBytes = 1024;
  localparam int SysexCapInt   = (SysexBufBytes < 2047) ? SysexBufBytes : 2047;
  localparam int SysexLenW     = 11;
  localparam logic [SysexLenW-1:0] SysexCap = SysexCapInt[SysexLenW-1:0];

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam int TdataW = 40;
  localparam int TuserW = 3;

  typedef enum logic [2:0] {
    KIND_CHAN      = 3'd0,
    KIND_COMMON    = 3'd1,
    KIND_SYSEX_END = 3'd2,
    KIND_REALTIME  = 3'd3,
    KIND_TUNE      = 3'd4
  } kind_e;

  // low three bits of a system common status
  typedef enum logic [2:0] {
    SC_SYSEX_START = 3'd0,
    SC_MTC         = 3'd1,
    SC_SONG_POS    = 3'd2,
    SC_SONG_SEL    = 3'd3,
    SC_UNDEF       = 3'd4,
    SC_BUS_SEL     = 3'd5,
    SC_TUNE        = 3'd6,
    SC_EOX         = 3'd7
  } sys_code_e;

  localparam logic [3:0] NibSystem = 4'hF;
  localparam logic [3:0] CodeTune  = 4'h6;

  typedef struct packed {
    kind_e                kind;
    logic [3:0]           status_nibble;
    logic [3:0]           chan_or_code;
    logic [6:0]           data_first;
    logic [6:0]           data_second;
    logic [SysexLenW-1:0] sysex_count;
    logic                 sysex_overflowed;
    logic                 last;
  } result_t;

  // up to two results per input byte; b only ever follows a
  typedef struct packed {
    logic    a_vld;
    logic    b_vld;
    result_t a;
    result_t b;
  } push_t;

  // data bytes a channel message needs, by status bits [6:4]
  function automatic logic [1:0] need_bytes(input logic [2:0] sel);
    logic [1:0] n;
    case (sel)
      3'd4:    n = 2'd1;
      3'd5:    n = 2'd1;
      3'd7:    n = 2'd0;
      default: n = 2'd2;
    endcase
    return n;
  endfunction

endpackage

>>> src/midi_stream_parser_core.sv
// Top level of the MIDI byte stream parser with running status.
//
// Input channel s_axis_*: one received MIDI byte per request in tdata[7:0].
// Output channel m_axis_*: one parsed message per request. tuser carries the
// message kind, tlast marks the last result caused by one input byte.
// A byte is registered on accept, then decoded against the parser state and,
// once the queue has room, written into a four-entry result queue; the queue
// count is registered, so a result shows on m_axis once it has been written.
// Throughput is one byte per cycle while the queue has room. Only a status
// byte that closes a sysex and is itself a tune request makes two results;
// the single output port then drains one per cycle while m_axis_tready_i
// is high and the queue absorbs the extra one. The input side stalls when
// the queue holds more than two results, so a receiver that holds
// m_axis_tready_i low backs up into s_axis_tready_o after a few requests;
// nothing is dropped. s_axis_tready_o depends only on registered state.
// Reset clears the running status, sysex count and flags and empties the
// queue; no clearing pass is needed.
`timescale 1ns / 1ps
module midi_stream_parser_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [7:0]                 s_axis_tdata_i,   // [7:0] rx_byte
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [3:0] status_nibble, [7:4] chan_or_code, [14:8] data_first,
  // [21:15] data_second, [32:22] sysex_count, [33] sysex_overflowed, rest 0
  output logic [msp_pkg::TdataW-1:0] m_axis_tdata_o,
  output logic [msp_pkg::TuserW-1:0] m_axis_tuser_o,   // [2:0] kind
  output logic                       m_axis_tlast_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       room;
  logic       step;

  msp_pkg::push_t   push;
  msp_pkg::result_t head;

  assign step            = in_vld_q && room;
  assign s_axis_tready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  msp_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .push_o (push)
  );

  msp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .head_o  (head)
  );

  assign m_axis_tdata_o = {6'd0, head.sysex_overflowed, head.sysex_count,
                           head.data_second, head.data_first,
                           head.chan_or_code, head.status_nibble};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule

>>> src/msp_decode.sv
// Parser state and per-byte decode into at most two results.
`timescale 1ns / 1ps
module msp_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output msp_pkg::push_t   push_o
);

  logic [3:0]  run_status_q, run_status_d;
  logic [3:0]  run_code_q, run_code_d;
  logic        have_status_q, have_status_d;
  logic        discard_q, discard_d;
  logic [1:0]  needed_q, needed_d;
  logic [1:0]  seen_q, seen_d;
  logic [6:0]  first_q, first_d;
  logic [6:0]  second_q, second_d;
  logic        in_sysex_q, in_sysex_d;
  logic [msp_pkg::SysexLenW-1:0] sx_len_q, sx_len_d;
  logic        sx_over_q, sx_over_d;

  msp_pkg::push_t push;
  logic [3:0] hi, lo;
  logic [1:0] seen_inc;

  assign hi       = byte_i[7:4];
  assign lo       = byte_i[3:0];
  assign seen_inc = seen_q + 2'd1;

  always_comb begin
    run_status_d  = run_status_q;
    run_code_d    = run_code_q;
    have_status_d = have_status_q;
    discard_d     = discard_q;
    needed_d      = needed_q;
    seen_d        = seen_q;
    first_d       = first_q;
    second_d      = second_q;
    in_sysex_d    = in_sysex_q;
    sx_len_d      = sx_len_q;
    sx_over_d     = sx_over_q;
    push          = '0;

    if (byte_i[7]) begin
      if (hi == msp_pkg::NibSystem && byte_i[3]) begin
        // realtime: passes through, touches no state
        push.a_vld           = 1'b1;
        push.a.kind          = msp_pkg::KIND_REALTIME;
        push.a.status_nibble = msp_pkg::NibSystem;
        push.a.chan_or_code  = lo;
      end else begin
        if (in_sysex_q) begin
          push.a_vld              = 1'b1;
          push.a.kind             = msp_pkg::KIND_SYSEX_END;
          push.a.status_nibble    = msp_pkg::NibSystem;
          push.a.sysex_count      = sx_len_q;
          push.a.sysex_overflowed = sx_over_q;
          in_sysex_d              = 1'b0;
          sx_over_d               = 1'b0;
        end
        if (hi == msp_pkg::NibSystem) begin
          case (msp_pkg::sys_code_e'(lo[2:0]))
            msp_pkg::SC_SYSEX_START: begin
              in_sysex_d = 1'b1;
              sx_len_d   = '0;
              sx_over_d  = 1'b0;
            end
            msp_pkg::SC_MTC, msp_pkg::SC_SONG_SEL: begin
              run_status_d  = msp_pkg::NibSystem;
              run_code_d    = lo;
              needed_d      = 2'd1;
              seen_d        = 2'd0;
              have_status_d = 1'b1;
              discard_d     = 1'b0;
            end
            msp_pkg::SC_SONG_POS, msp_pkg::SC_BUS_SEL: begin
              run_status_d  = msp_pkg::NibSystem;
              run_code_d    = lo;
              needed_d      = 2'd2;
              seen_d        = 2'd0;
              have_status_d = 1'b1;
              discard_d     = 1'b0;
            end
            msp_pkg::SC_TUNE: begin
              if (push.a_vld) begin
                push.b_vld           = 1'b1;
                push.b.kind          = msp_pkg::KIND_TUNE;
                push.b.status_nibble = msp_pkg::NibSystem;
                push.b.chan_or_code  = msp_pkg::CodeTune;
              end else begin
                push.a_vld           = 1'b1;
                push.a.kind          = msp_pkg::KIND_TUNE;
                push.a.status_nibble = msp_pkg::NibSystem;
                push.a.chan_or_code  = msp_pkg::CodeTune;
              end
            end
            msp_pkg::SC_UNDEF: begin
              discard_d = 1'b1;
              seen_d    = 2'd0;
            end
            default: begin
              // EOX: any open sysex was reported above
            end
          endcase
        end else begin
          run_status_d  = hi;
          run_code_d    = lo;
          needed_d      = msp_pkg::need_bytes(hi[2:0]);
          seen_d        = 2'd0;
          have_status_d = 1'b1;
          discard_d     = 1'b0;
        end
      end
    end else if (in_sysex_q) begin
      if (sx_len_q < msp_pkg::SysexCap) begin
        sx_len_d = sx_len_q + 1'b1;
      end else begin
        sx_over_d = 1'b1;
      end
    end else if (have_status_q && !discard_q) begin
      if (seen_q == 2'd0) begin
        first_d = byte_i[6:0];
      end else begin
        second_d = byte_i[6:0];
      end
      seen_d = seen_inc;
      if (seen_inc >= needed_q) begin
        seen_d               = 2'd0;
        push.a_vld           = 1'b1;
        push.a.kind          = (run_status_q == msp_pkg::NibSystem) ?
                               msp_pkg::KIND_COMMON : msp_pkg::KIND_CHAN;
        push.a.status_nibble = run_status_q;
        push.a.chan_or_code  = run_code_q;
        push.a.data_first    = first_d;
        push.a.data_second   = second_d;
      end
    end

    if (push.b_vld) begin
      push.b.last = 1'b1;
    end else begin
      push.a.last = push.a_vld;
    end
  end

  always_comb begin
    push_o       = push;
    push_o.a_vld = push.a_vld & step_i;
    push_o.b_vld = push.b_vld & step_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_status_q  <= '0;
      run_code_q    <= '0;
      have_status_q <= 1'b0;
      discard_q     <= 1'b0;
      needed_q      <= '0;
      seen_q        <= '0;
      first_q       <= '0;
      second_q      <= '0;
      in_sysex_q    <= 1'b0;
      sx_len_q      <= '0;
      sx_over_q     <= 1'b0;
    end else if (step_i) begin
      run_status_q  <= run_status_d;
      run_code_q    <= run_code_d;
      have_status_q <= have_status_d;
      discard_q     <= discard_d;
      needed_q      <= needed_d;
      seen_q        <= seen_d;
      first_q       <= first_d;
      second_q      <= second_d;
      in_sysex_q    <= in_sysex_d;
      sx_len_q      <= sx_len_d;
      sx_over_q     <= sx_over_d;
    end
  end

endmodule

>>> src/msp_out_fifo.sv
// Result queue: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps
module msp_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  msp_pkg::push_t   push_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output msp_pkg::result_t head_o
);

  msp_pkg::result_t mem_q [msp_pkg::FifoDepth];
  logic [msp_pkg::FifoPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [msp_pkg::FifoCntW-1:0] cnt_q, cnt_d;
  logic [msp_pkg::FifoPtrW-1:0] wr_ptr_nxt;
  logic pop;
  logic [1:0] push_n;

  assign wr_ptr_nxt = wr_ptr_q + 1'b1;
  assign pop        = valid_o && ready_i;
  assign push_n     = {1'b0, push_i.a_vld} + {1'b0, push_i.b_vld};
  assign valid_o    = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];
  // room for two whole results, from registered state only
  assign room_o     = (cnt_q <= msp_pkg::FifoCntW'(msp_pkg::FifoDepth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + msp_pkg::FifoPtrW'(push_n);
    rd_ptr_d = rd_ptr_q + msp_pkg::FifoPtrW'(pop);
    cnt_d    = cnt_q + msp_pkg::FifoCntW'(push_n) - msp_pkg::FifoCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.a_vld) begin
      mem_q[wr_ptr_q] <= push_i.a;
    end
    if (push_i.b_vld) begin
      mem_q[wr_ptr_nxt] <= push_i.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= msp_pkg::FifoCntW'(msp_pkg::FifoDepth))
    else $error("result queue count past depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.a_vld |-> room_o)
    else $error("result pushed without room");

  a_b_after_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.b_vld |-> push_i.a_vld)
    else $error("second result without first");

  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.b_vld |-> (push_i.b.last && !push_i.a.last))
    else $error("last flag on wrong result of a pair");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n == 2'd0 && !pop) |=> $stable(cnt_q))
    else $error("queue count moved with no request");

endmodule

>>> tb/midi_stream_parser_core_tb.sv
// Self-checking testbench for midi_stream_parser_core: directed and random MIDI byte streams.
`timescale 1ns / 1ps
module midi_stream_parser_core_tb;

  localparam int RandItems   = 680;   // counted random bytes, split around the long sysex
  localparam int HoldAfter   = 60;    // results seen before the long receiver stall
  localparam int HoldCycles  = 300;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 20;

  localparam logic [3:0] NibSys  = msp_pkg::NibSystem;
  localparam logic [7:0] StSysex = {msp_pkg::NibSystem, 1'b0, msp_pkg::SC_SYSEX_START};
  localparam logic [7:0] StUndef = {msp_pkg::NibSystem, 1'b0, msp_pkg::SC_UNDEF};
  localparam logic [7:0] StTune  = {msp_pkg::NibSystem, 1'b0, msp_pkg::SC_TUNE};
  localparam logic [7:0] StEox   = {msp_pkg::NibSystem, 1'b0, msp_pkg::SC_EOX};

  typedef enum int {
    CHK_PREDICT,
    CHK_QUIET,
    CHK_FIXED
  } row_chk_e;

  typedef struct {
    logic [7:0]       rx;
    row_chk_e         chk;
    msp_pkg::result_t want;
  } dir_row_t;

  logic                       clk_i   = 1'b0;
  logic                       rst_ni  = 1'b0;
  logic                       s_valid = 1'b0;
  logic [7:0]                 s_data  = 8'h00;
  logic                       m_ready = 1'b0;
  logic                       s_tready;
  logic                       m_tvalid;
  logic [msp_pkg::TdataW-1:0] m_tdata;
  logic [msp_pkg::TuserW-1:0] m_tuser;
  logic                       m_tlast;

  midi_stream_parser_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // parser state as the testbench sees it
  logic [3:0]  pr_nib    = '0;
  logic [3:0]  pr_code   = '0;
  logic        pr_have   = 1'b0;
  logic        pr_skip   = 1'b0;
  logic [1:0]  pr_need   = '0;
  logic [1:0]  pr_seen   = '0;
  logic [6:0]  pr_first  = '0;
  logic [6:0]  pr_second = '0;
  logic        pr_in_sx  = 1'b0;
  logic [10:0] pr_sx_len = '0;
  logic        pr_sx_ovf = 1'b0;

  msp_pkg::result_t step_res[$];    // results caused by the byte just parsed
  msp_pkg::result_t want_msgs[$];   // results still owed by the block
  dir_row_t         dir_rows[$];
  logic [7:0]       tx_bytes[$];
  logic [7:0]       gen_run = 8'h00; // running status the generator relies on, 0 if none

  int errors      = 0;
  int sent_cnt    = 0;
  int got_cnt     = 0;
  int sx_cnt      = 0;
  int ovf_cnt     = 0;
  int idle_cycles = 0;

  function automatic msp_pkg::result_t mk(input msp_pkg::kind_e k,
                                          input logic [3:0] nib, code,
                                          input logic [6:0] d1, d2,
                                          input logic [10:0] cnt,
                                          input logic ovf, lst);
    msp_pkg::result_t r;
    r.kind             = k;
    r.status_nibble    = nib;
    r.chan_or_code     = code;
    r.data_first       = d1;
    r.data_second      = d2;
    r.sysex_count      = cnt;
    r.sysex_overflowed = ovf;
    r.last             = lst;
    return r;
  endfunction

  // data bytes that follow a channel or system common status
  function automatic int msg_len(input logic [7:0] st);
    if (st[7:4] == msp_pkg::NibSystem) begin
      case (msp_pkg::sys_code_e'(st[2:0]))
        msp_pkg::SC_MTC, msp_pkg::SC_SONG_SEL:     return 1;
        msp_pkg::SC_SONG_POS, msp_pkg::SC_BUS_SEL: return 2;
        default:                                   return 0;
      endcase
    end
    case (st[6:4])
      3'd4, 3'd5: return 1;
      default:    return 2;
    endcase
  endfunction

  task automatic load_status(input logic [7:0] st);
    pr_nib  = st[7:4];
    pr_code = st[3:0];
    pr_need = 2'(msg_len(st));
    pr_seen = '0;
    pr_have = 1'b1;
    pr_skip = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] rx);
    step_res = {};
    if (rx[7]) begin
      if (rx[7:4] == msp_pkg::NibSystem && rx[3]) begin
        step_res.push_back(mk(msp_pkg::KIND_REALTIME, NibSys, rx[3:0], '0, '0, '0,
                              1'b0, 1'b0));
      end else begin
        // any other status closes an open sysex first
        if (pr_in_sx) begin
          step_res.push_back(mk(msp_pkg::KIND_SYSEX_END, NibSys, 4'h0, '0, '0, pr_sx_len,
                                pr_sx_ovf, 1'b0));
          pr_in_sx  = 1'b0;
          pr_sx_ovf = 1'b0;
        end
        if (rx[7:4] == msp_pkg::NibSystem) begin
          case (msp_pkg::sys_code_e'(rx[2:0]))
            msp_pkg::SC_SYSEX_START: begin
              pr_in_sx  = 1'b1;
              pr_sx_len = '0;
              pr_sx_ovf = 1'b0;
            end
            msp_pkg::SC_TUNE: begin
              step_res.push_back(mk(msp_pkg::KIND_TUNE, NibSys, msp_pkg::CodeTune, '0, '0,
                                    '0, 1'b0, 1'b0));
            end
            msp_pkg::SC_UNDEF: begin
              pr_skip = 1'b1;
              pr_seen = '0;
            end
            msp_pkg::SC_EOX: begin
            end
            default: load_status(rx);
          endcase
        end else begin
          load_status(rx);
        end
      end
    end else if (pr_in_sx) begin
      if (pr_sx_len < msp_pkg::SysexCap) pr_sx_len = pr_sx_len + 11'd1;
      else pr_sx_ovf = 1'b1;
    end else if (pr_have && !pr_skip) begin
      if (pr_seen == 2'd0) pr_first = rx[6:0];
      else pr_second = rx[6:0];
      pr_seen = pr_seen + 2'd1;
      if (pr_seen >= pr_need) begin
        pr_seen = '0;
        step_res.push_back(mk((pr_nib == msp_pkg::NibSystem) ? msp_pkg::KIND_COMMON :
                              msp_pkg::KIND_CHAN, pr_nib, pr_code, pr_first, pr_second,
                              '0, 1'b0, 1'b0));
      end
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
  endtask

  task automatic add_row(input logic [7:0] rx, input row_chk_e chk,
                         input msp_pkg::result_t want);
    dir_row_t r;
    r.rx   = rx;
    r.chk  = chk;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  // occasionally slip a realtime byte in front
  task automatic put(input logic [7:0] b);
    if ($urandom_range(0, 11) == 0) tx_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
    tx_bytes.push_back(b);
  endtask

  task automatic gen_stream(input int count);
    int                 made;
    int                 pick;
    int                 n;
    logic [7:0]         st;
    msp_pkg::sys_code_e sc;
    made = 0;
    while (made < count) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 60) begin
        if (gen_run == 8'h00 || $urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 4) == 0) begin
            sc = msp_pkg::sys_code_e'(3'($urandom_range(1, 3)));
            if ($urandom_range(0, 3) == 0) sc = msp_pkg::SC_BUS_SEL;
            st = {msp_pkg::NibSystem, 1'b0, sc};
          end else begin
            st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
          end
          put(st);
          made++;
          gen_run = st;
        end
        n = msg_len(gen_run);
        if ($urandom_range(0, 14) == 0) n--;   // cut short
        repeat (n) begin
          put(8'($urandom_range(0, 127)));
          made++;
        end
      end else if (pick < 72) begin
        put(StSysex);
        made++;
        repeat ($urandom_range(0, 24)) begin
          put(8'($urandom_range(0, 127)));
          made++;
        end
        case ($urandom_range(0, 3))
          0: gen_run = 8'h00;   // left open, the next status closes it
          1: begin
            put(StTune);
            made++;
          end
          default: begin
            put(StEox);
            made++;
          end
        endcase
      end else if (pick < 78) begin
        put(StTune);
        made++;
      end else if (pick < 84) begin
        put(StUndef);
        made++;
        gen_run = 8'h00;
        repeat ($urandom_range(0, 4)) put(8'($urandom_range(0, 127)));
      end else if (pick < 88) begin
        put(StEox);
        made++;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          put(8'($urandom));
          made++;
        end
        gen_run = 8'h00;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] rx, input row_chk_e chk,
                           input msp_pkg::result_t want);
    int gap;
    gap = (sent_cnt % 80 < 20) ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= rx;
    do @(posedge clk_i); while (!s_tready);
    parse_byte(rx);
    case (chk)
      CHK_PREDICT: foreach (step_res[i]) want_msgs.push_back(step_res[i]);
      CHK_FIXED:   want_msgs.push_back(want);
      default: begin
      end
    endcase
    sent_cnt++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want_v,
                           input logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
    end
  endtask

  initial begin : stim
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(8'h00, CHK_QUIET, '0);   // data before any status
    add_row(8'hFF, CHK_FIXED, mk(msp_pkg::KIND_REALTIME, NibSys, 4'hF, '0, '0, '0,
                                 1'b0, 1'b1));
    add_row(8'hF9, CHK_FIXED, mk(msp_pkg::KIND_REALTIME, NibSys, 4'h9, '0, '0, '0,
                                 1'b0, 1'b1));
    add_row(8'h9F, CHK_QUIET, '0);
    add_row(8'h7F, CHK_QUIET, '0);
    add_row(8'h00, CHK_FIXED, mk(msp_pkg::KIND_CHAN, 4'h9, 4'hF, 7'h7F, 7'h00, '0,
                                 1'b0, 1'b1));
    add_row(8'hC0, CHK_PREDICT, '0);
    add_row(8'h55, CHK_PREDICT, '0);
    add_row(8'hE1, CHK_PREDICT, '0);
    add_row(8'h00, CHK_PREDICT, '0);
    add_row(8'hFD, CHK_PREDICT, '0);   // realtime inside a message
    add_row(8'h7F, CHK_PREDICT, '0);
    add_row(8'hF2, CHK_PREDICT, '0);
    add_row(8'h01, CHK_PREDICT, '0);
    add_row(8'h02, CHK_PREDICT, '0);
    add_row(8'h03, CHK_PREDICT, '0);   // running status on a common message
    add_row(8'h04, CHK_PREDICT, '0);
    add_row(StSysex, CHK_PREDICT, '0);
    add_row(8'h11, CHK_PREDICT, '0);
    add_row(8'hF8, CHK_PREDICT, '0);   // realtime does not end the sysex
    add_row(8'h22, CHK_PREDICT, '0);
    add_row(StTune, CHK_PREDICT, '0);  // sysex end, then tune request
    add_row(StUndef, CHK_PREDICT, '0);
    add_row(8'h33, CHK_QUIET, '0);
    add_row(StEox, CHK_QUIET, '0);     // bare end with no sysex open
    add_row(StSysex, CHK_PREDICT, '0);
    add_row(StEox, CHK_FIXED, mk(msp_pkg::KIND_SYSEX_END, NibSys, 4'h0, '0, '0, '0,
                                 1'b0, 1'b1));
    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].chk, dir_rows[i].want);

    gen_stream(RandItems / 2);
    // one sysex past the buffer size
    put(StSysex);
    repeat (msp_pkg::SysexCapInt + $urandom_range(1, 4)) put(8'($urandom_range(0, 127)));
    put(StEox);
    gen_stream(RandItems / 2);
    foreach (tx_bytes[i]) send_byte(tx_bytes[i], CHK_PREDICT, '0);
    s_valid <= 1'b0;

    while (want_msgs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d bytes and checked %0d results, %0d of them sysex reports (%0d overflowed).",
             sent_cnt, got_cnt, sx_cnt, ovf_cnt);
    $display("Both sides idled at random, and the receiver stalled once for %0d cycles.",
             HoldCycles);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : rx_side
    int gap;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      // long stall so the result queue fills and backs up into the input
      if (!held && got_cnt >= HoldAfter) begin
        held = 1'b1;
        m_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      gap = (got_cnt % 64 < 16) ? 0 : int'($urandom_range(0, 10));
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  always @(posedge clk_i) begin : check_out
    msp_pkg::result_t want;
    if (rst_ni && m_tvalid && m_ready) begin
      got_cnt++;
      if (want_msgs.size() == 0) begin
        errors++;
        $display("%0t: result with none pending, expected nothing got tuser=%0d tdata=%h",
                 $time, m_tuser, m_tdata);
      end else begin
        want = want_msgs.pop_front();
        cmp_field("kind", 32'(want.kind), 32'(m_tuser));
        cmp_field("status_nibble", 32'(want.status_nibble), 32'(m_tdata[3:0]));
        cmp_field("chan_or_code", 32'(want.chan_or_code), 32'(m_tdata[7:4]));
        cmp_field("data_first", 32'(want.data_first), 32'(m_tdata[14:8]));
        cmp_field("data_second", 32'(want.data_second), 32'(m_tdata[21:15]));
        cmp_field("sysex_count", 32'(want.sysex_count), 32'(m_tdata[32:22]));
        cmp_field("sysex_overflowed", 32'(want.sysex_overflowed), 32'(m_tdata[33]));
        cmp_field("tdata padding", 32'd0, 32'(m_tdata[msp_pkg::TdataW-1:34]));
        cmp_field("last", 32'(want.last), 32'(m_tlast));
        if (want.kind == msp_pkg::KIND_SYSEX_END) begin
          sx_cnt++;
          if (want.sysex_overflowed) ovf_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_tready) || (m_tvalid && m_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: watchdog, no request moved for %0d cycles", $time, IdleLimit);
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

>>> sim.f
src/msp_pkg.sv
src/msp_decode.sv
src/msp_out_fifo.sv
src/midi_stream_parser_core.sv
tb/midi_stream_parser_core_tb.sv
